[src/masked_byte_pattern_scanner_assert.svh]
// Assertion macros used by the checker of the byte pattern scanner.
`ifndef MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCANNER_ASSERT_SVH

// The property holds in the same cycle as its trigger; clk and rst come from the scope of use.
`define MBPS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanner check failed");

// The property must hold in the cycle after its trigger.
`define MBPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanner check failed");

`endif

[src/mbps_pkg.sv]
// Package with register codes, constants and helpers of the byte pattern scanner.
`timescale 1ns / 1ps
`default_nettype none
package mbps_pkg;

  localparam int ADDR_W        = 6;
  localparam int DATA_W        = 64;
  localparam int PATTERN_BYTES = 32;
  localparam int PATTERN_WORDS = 4;

  typedef enum logic [2:0] {
    REG_PATTERN_0      = 3'd0,
    REG_PATTERN_1      = 3'd1,
    REG_PATTERN_2      = 3'd2,
    REG_PATTERN_3      = 3'd3,
    REG_CARE_MASK      = 3'd4,
    REG_PATTERN_LENGTH = 3'd5
  } cfg_reg_t;

  typedef logic [PATTERN_WORDS-1:0][63:0] pattern_words_t;

  // Byte idx of the pattern, with byte 0 in the low bits of word 0.
  function automatic logic [7:0] pattern_byte(input pattern_words_t words,
                                              input logic [4:0] idx);
    logic [63:0] w;
    w = words[idx[4:3]];
    return w[{idx[2:0], 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

[src/masked_byte_pattern_scanner.sv]
// Top level of the masked byte pattern scanner: config port, cell chain, result register.
//
// Usage:
//   Program the pattern words, the care mask and the pattern length through the
//   APB-style port (64-bit registers at byte addresses 0, 8, ... 40). Then stream
//   memory bytes on the data channel (data_byte, byte_address, region_start,
//   scan_start with data_valid/data_ready), one transfer per cycle at full rate.
//   The first window that matches gives one transfer on the match channel with
//   the address of its first byte; after that the block stays silent until a
//   byte arrives with scan_start set. region_start restarts the window fill.
//   The result is registered; it appears in the cycle after the completing byte.
//   Throughput: one byte per cycle while data_ready is high (combinational compare).
//   In the cycle after a configuration write data_ready is low while the aligned
//   pattern registers reload. Reset clears the scan state and the configuration
//   registers; the pattern length resets to one, and data_ready stays low for
//   the first cycle after reset. While a result waits for match_ready,
//   data_ready is low, so no byte is taken until the result transfer completes.
`timescale 1ns / 1ps
`default_nettype none
module masked_byte_pattern_scanner #(
  parameter int MAX_PATTERN = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mbps_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mbps_pkg::DATA_W-1:0] pwdata,
  output logic      [mbps_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic [7:0]                  data_byte,
  input  wire logic [63:0]                 byte_address,
  input  wire logic                        region_start,
  input  wire logic                        scan_start,
  input  wire logic                        data_valid,
  output logic                             data_ready,
  output logic      [63:0]                 match_address,
  output logic                             match_valid,
  input  wire logic                        match_ready
);
  import mbps_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);

  pattern_words_t pattern_words;
  logic [31:0]    care_mask;
  logic [5:0]     pattern_length;
  logic           cfg_write;
  logic           settle;

  logic [MAX_PATTERN-1:0][7:0] aligned_pattern;
  logic [MAX_PATTERN-1:0]      aligned_care;
  logic [LW-1:0]               length_eff;

  logic [7:0]             window [0:MAX_PATTERN-1];
  logic [MAX_PATTERN-1:0] hit;
  logic                   accept;
  logic [LW-1:0]          fill_count;
  logic [LW-1:0]          fill_base;
  logic [LW-1:0]          fill_count_next;
  logic                   found;
  logic                   found_eff;
  logic                   match;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      care_mask      <= '0;
      pattern_length <= 6'd1;
    end else if (cfg_write) begin
      case (cfg_reg_t'(paddr[5:3]))
        REG_PATTERN_0:      pattern_words[0] <= pwdata;
        REG_PATTERN_1:      pattern_words[1] <= pwdata;
        REG_PATTERN_2:      pattern_words[2] <= pwdata;
        REG_PATTERN_3:      pattern_words[3] <= pwdata;
        REG_CARE_MASK:      care_mask        <= pwdata[31:0];
        REG_PATTERN_LENGTH: pattern_length   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[5:3]))
      REG_PATTERN_0:      prdata = pattern_words[0];
      REG_PATTERN_1:      prdata = pattern_words[1];
      REG_PATTERN_2:      prdata = pattern_words[2];
      REG_PATTERN_3:      prdata = pattern_words[3];
      REG_CARE_MASK:      prdata = {32'd0, care_mask};
      REG_PATTERN_LENGTH: prdata = {58'd0, pattern_length};
      default:            prdata = '0;
    endcase
  end

  // The aligned pattern is registered behind the configuration registers, so input waits while it reloads.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= cfg_write;
    end
  end

  mbps_align #(
    .MAX_PATTERN (MAX_PATTERN),
    .LW          (LW)
  ) u_align (
    .clk             (clk),
    .pattern_words   (pattern_words),
    .care_mask       (care_mask),
    .pattern_length  (pattern_length),
    .aligned_pattern (aligned_pattern),
    .aligned_care    (aligned_care),
    .length_eff      (length_eff)
  );

  assign data_ready = !rst && !settle && (!match_valid || match_ready);
  assign accept     = data_valid && data_ready;

  // Window chain: window[0] is the incoming byte, window[k] the byte k transfers back.
  assign window[0] = data_byte;

  for (genvar k = 0; k < MAX_PATTERN - 1; k++) begin : g_cell
    mbps_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (accept),
      .byte_in  (window[k]),
      .pat_byte (aligned_pattern[k]),
      .care     (aligned_care[k]),
      .byte_out (window[k+1]),
      .hit      (hit[k])
    );
  end

  assign hit[MAX_PATTERN-1] = !aligned_care[MAX_PATTERN-1] ||
                              (window[MAX_PATTERN-1] == aligned_pattern[MAX_PATTERN-1]);

  // Fill count restarts on a new region or a new scan and saturates at the window size.
  always_comb begin
    fill_base = (scan_start || region_start) ? '0 : fill_count;
    if (fill_base == LW'(MAX_PATTERN)) begin
      fill_count_next = fill_base;
    end else begin
      fill_count_next = fill_base + LW'(1);
    end
  end

  assign found_eff = found && !scan_start;
  assign match     = !found_eff && (fill_count_next >= length_eff) && (&hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      found       <= 1'b0;
      match_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill_count <= fill_count_next;
        found      <= found_eff || match;
      end
      if (accept && match) begin
        match_valid <= 1'b1;
      end else if (match_ready) begin
        match_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && match) begin
      match_address <= byte_address - 64'(length_eff) + 64'd1;
    end
  end

endmodule
`default_nettype wire

[src/mbps_cell.sv]
// One window cell: compares its incoming window byte and registers it as the next window byte.
`timescale 1ns / 1ps
`default_nettype none
module mbps_cell (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       shift,
  input  wire logic [7:0] byte_in,
  input  wire logic [7:0] pat_byte,
  input  wire logic       care,
  output logic      [7:0] byte_out,
  output logic            hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_out <= '0;
    end else if (shift) begin
      byte_out <= byte_in;
    end
  end

  // A wildcard position matches any byte.
  assign hit = !care || (byte_in == pat_byte);

endmodule
`default_nettype wire

[src/mbps_align.sv]
// Aligns pattern and care bits to window positions for the configured length.
`timescale 1ns / 1ps
`default_nettype none
module mbps_align #(
  parameter int MAX_PATTERN = 32,
  parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
  input  wire logic                          clk,
  input  wire mbps_pkg::pattern_words_t      pattern_words,
  input  wire logic [31:0]                   care_mask,
  input  wire logic [5:0]                    pattern_length,
  output logic      [MAX_PATTERN-1:0][7:0]   aligned_pattern,
  output logic      [MAX_PATTERN-1:0]        aligned_care,
  output logic      [LW-1:0]                 length_eff
);
  import mbps_pkg::*;

  logic [MAX_PATTERN-1:0][7:0] aligned_pattern_next;
  logic [MAX_PATTERN-1:0]      aligned_care_next;
  logic [6:0]                  len7;

  // Window position k (k bytes back from the newest) faces pattern byte len-1-k.
  always_comb begin
    logic [6:0] idx;
    idx  = '0;
    len7 = {1'b0, pattern_length};
    if (len7 == 7'd0) begin
      len7 = 7'd1;
    end else if (len7 > 7'(MAX_PATTERN)) begin
      len7 = 7'(MAX_PATTERN);
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = len7 - 7'(k) - 7'd1;
      aligned_pattern_next[k] = '0;
      aligned_care_next[k]    = 1'b0;
      if ((7'(k) < len7) && (idx < 7'(PATTERN_BYTES))) begin
        aligned_pattern_next[k] = pattern_byte(pattern_words, idx[4:0]);
        aligned_care_next[k]    = care_mask[idx[4:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    aligned_pattern <= aligned_pattern_next;
    aligned_care    <= aligned_care_next;
    length_eff      <= LW'(len7);
  end

endmodule
`default_nettype wire

[src/mbps_checker.sv]
// Port-level checker for the byte pattern scanner and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_byte_pattern_scanner_assert.svh"
module mbps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic        data_valid,
  input wire logic        data_ready,
  input wire logic        scan_start,
  input wire logic        match_valid,
  input wire logic        match_ready,
  input wire logic [63:0] match_address
);

  // A stalled result keeps its address.
  `MBPS_ASSERT_NEXT(a_result_held, match_valid && !match_ready, match_valid && $stable(match_address))

  // After a result is taken, another needs a fresh scan started by the byte taken alongside.
  `MBPS_ASSERT_NEXT(a_one_per_scan, match_valid && match_ready && !(data_valid && data_ready && scan_start), !match_valid)

  // A new result always follows a byte transfer.
  `MBPS_ASSERT_SAME(a_result_from_input, $rose(match_valid), $past(data_valid && data_ready))

  // Input pauses in the cycle after a configuration write.
  `MBPS_ASSERT_NEXT(a_cfg_settle, psel && penable && pwrite, !data_ready)

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);
`default_nettype wire

[verif/masked_byte_pattern_scanner_test.sv]
// Self-checking testbench for the masked byte pattern scanner.
`timescale 1ns / 1ps
module masked_byte_pattern_scanner_test;
  import mbps_pkg::*;

  localparam int PATTERN_MAX    = PATTERN_BYTES;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 75;

  typedef struct {
    logic [7:0]  data;
    logic [63:0] addr;
    logic        region;
    logic        scan;
  } scan_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic [7:0]          data_byte = '0;
  logic [63:0]         byte_address = '0;
  logic                region_start = 1'b0;
  logic                scan_start = 1'b0;
  logic                data_valid = 1'b0;
  logic                data_ready;
  logic [63:0]         match_address;
  logic                match_valid;
  logic                match_ready = 1'b0;

  // Predictor copy of the registers and of the scan state.
  logic [63:0] pat_words [0:3] = '{default: '0};
  logic [31:0] care_bits = '0;
  logic [5:0]  pat_len_reg = 6'd1;
  logic [7:0]  recent_bytes [0:PATTERN_MAX-2] = '{default: '0};
  int          fill_level = 0;
  bit          already_found = 1'b0;

  scan_byte_t  pending_bytes [$];
  logic [63:0] expected_starts [$];
  scan_byte_t  next_byte;
  logic [63:0] start_addr;
  logic [63:0] want_start;

  int  pushed = 0;
  int  accepted = 0;
  int  matches_checked = 0;
  int  scans_started = 0;
  int  settings_used = 1;
  int  errors = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  bit  sender_gaps = 1'b0;
  bit  receiver_gaps = 1'b0;

  masked_byte_pattern_scanner u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .data_byte     (data_byte),
    .byte_address  (byte_address),
    .region_start  (region_start),
    .scan_start    (scan_start),
    .data_valid    (data_valid),
    .data_ready    (data_ready),
    .match_address (match_address),
    .match_valid   (match_valid),
    .match_ready   (match_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] wanted_byte(input int j);
    return pat_words[j / 8][(j % 8) * 8 +: 8];
  endfunction

  // A length of zero acts as one, and lengths past the window size are clamped.
  function automatic int eff_len();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > PATTERN_MAX) return PATTERN_MAX;
    return pat_len_reg;
  endfunction

  function automatic bit scan_step(input logic [7:0] cur, input logic [63:0] addr,
                                   input logic region, input logic scan,
                                   output logic [63:0] start);
    int         len;
    int         j;
    int         k;
    bit         hit;
    logic [7:0] b;
    len = eff_len();
    hit = 1'b0;
    start = '0;
    if (scan) begin
      already_found = 1'b0;
      fill_level = 0;
    end
    if (region) fill_level = 0;
    if (fill_level < PATTERN_MAX) fill_level++;
    if (!already_found && fill_level >= len) begin
      hit = 1'b1;
      for (j = 0; j < len; j++) begin
        b = (j == len - 1) ? cur : recent_bytes[len - 2 - j];
        if (care_bits[j] && b != wanted_byte(j)) hit = 1'b0;
      end
      if (hit) begin
        already_found = 1'b1;
        start = addr - 64'(len - 1);
      end
    end
    for (k = PATTERN_MAX - 2; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
    recent_bytes[0] = cur;
    return hit;
  endfunction

  // Sender: one transfer per accepted byte, with optional gaps between bytes.
  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (data_valid && data_ready) begin
        if (scan_start) scans_started++;
        if (scan_step(data_byte, byte_address, region_start, scan_start, start_addr)) begin
          expected_starts.push_back(start_addr);
        end
        accepted++;
      end
      if (!data_valid || data_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          data_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          data_byte    <= next_byte.data;
          byte_address <= next_byte.addr;
          region_start <= next_byte.region;
          scan_start   <= next_byte.scan;
          data_valid   <= 1'b1;
          if (sender_gaps) send_gap = draw_gap();
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each match transfer against the oldest expected start address.
  always @(posedge clk) begin
    if (rst) begin
      match_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (match_valid && match_ready) begin
        if (expected_starts.size() == 0) begin
          $error("match_address: no transfer expected, got %h", match_address);
          errors++;
        end else begin
          want_start = expected_starts.pop_front();
          if (match_address !== want_start) begin
            $error("match_address: expected %h, got %h", want_start, match_address);
            errors++;
          end
          matches_checked++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        match_ready <= 1'b0;
      end else begin
        match_ready <= 1'b1;
        if (receiver_gaps && $urandom_range(0, 3) == 0) stall_left = draw_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (match_valid && match_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles = 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("masked_byte_pattern_scanner_test failed");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  task automatic push_item(input logic [7:0] d, input logic [63:0] a,
                           input logic r, input logic s);
    scan_byte_t item;
    item.data = d;
    item.addr = a;
    item.region = r;
    item.scan = s;
    pending_bytes.push_back(item);
    pushed++;
  endtask

  // Waits until every byte is taken and every match has arrived, then lets the
  // pipeline settle.
  task automatic wait_idle();
    while (pushed != accepted || expected_starts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t r, input logic [63:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_PATTERN_0:      pat_words[0] = v;
      REG_PATTERN_1:      pat_words[1] = v;
      REG_PATTERN_2:      pat_words[2] = v;
      REG_PATTERN_3:      pat_words[3] = v;
      REG_CARE_MASK:      care_bits = v[31:0];
      REG_PATTERN_LENGTH: pat_len_reg = v[5:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [63:0] w0, input logic [63:0] w1,
                             input logic [63:0] w2, input logic [63:0] w3,
                             input logic [31:0] mask, input logic [5:0] len);
    wait_idle();
    cfg_write(REG_PATTERN_0, w0);
    cfg_write(REG_PATTERN_1, w1);
    cfg_write(REG_PATTERN_2, w2);
    cfg_write(REG_PATTERN_3, w3);
    cfg_write(REG_CARE_MASK, {32'd0, mask});
    cfg_write(REG_PATTERN_LENGTH, {58'd0, len});
    settings_used++;
  endtask

  // Mostly scans that carry one copy of the pattern, sometimes damaged or split
  // by a region boundary, mixed with loose noise bytes.
  task automatic scan_burst(input int n);
    int          target;
    int          len;
    int          k;
    int          cut;
    int          region_at;
    bit          corrupt;
    logic [7:0]  b;
    logic [63:0] a;
    target = pushed + n;
    while (pushed < target) begin
      len = eff_len();
      if ($urandom_range(0, 7) == 0) a = 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 15));
      else a = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) begin
        push_item(8'($urandom_range(0, 255)), a, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 7) == 0);
        continue;
      end
      push_item(8'($urandom_range(0, 255)), a, 1'($urandom_range(0, 1)), 1'b1);
      a++;
      repeat ($urandom_range(0, 5)) begin
        push_item(8'($urandom_range(0, 255)), a, $urandom_range(0, 9) == 0, 1'b0);
        a++;
      end
      corrupt = ($urandom_range(0, 5) == 0);
      cut = $urandom_range(0, len - 1);
      region_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len - 1) : -1;
      for (k = 0; k < len; k++) begin
        b = care_bits[k] ? wanted_byte(k) : 8'($urandom_range(0, 255));
        if (corrupt && k == cut) b = b ^ (8'h01 << $urandom_range(0, 7));
        push_item(b, a, k == region_at, 1'b0);
        a++;
      end
      repeat ($urandom_range(0, 3)) begin
        push_item(8'($urandom_range(0, 255)), a, 1'b0, 1'b0);
        a++;
      end
    end
  endtask

  initial begin
    int          p;
    int          r;
    logic [63:0] w [0:3];
    logic [31:0] mask;
    logic [5:0]  len;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: length one with every byte a wildcard, so each new scan
    // matches on its first byte and a region restart alone does not rearm.
    push_item(8'h00, 64'h0, 1'b0, 1'b0);
    push_item(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    push_item(8'h5A, 64'h1000, 1'b0, 1'b1);
    push_item(8'h3C, 64'h1001, 1'b0, 1'b0);

    load_config(64'h1234_5678_DDCC_BBAA, '1, '0, {$urandom, $urandom},
                32'h0000_000B, 6'd4);
    // The match start wraps below address zero; byte two is a wildcard.
    push_item(8'hAA, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b1);
    push_item(8'hBB, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    push_item(8'h00, 64'h0, 1'b0, 1'b0);
    push_item(8'hDD, 64'h1, 1'b0, 1'b0);
    // A region boundary inside the pattern hides it; the later full copy matches.
    push_item(8'hAA, 64'h100, 1'b0, 1'b1);
    push_item(8'hBB, 64'h101, 1'b1, 1'b0);
    push_item(8'h12, 64'h102, 1'b0, 1'b0);
    push_item(8'hDD, 64'h103, 1'b0, 1'b0);
    push_item(8'hAA, 64'h104, 1'b0, 1'b0);
    push_item(8'hBB, 64'h105, 1'b0, 1'b0);
    push_item(8'hCC, 64'h106, 1'b0, 1'b0);
    push_item(8'hDD, 64'h107, 1'b0, 1'b0);
    push_item(8'hAA, 64'h108, 1'b0, 1'b0);
    push_item(8'hBB, 64'h109, 1'b0, 1'b0);
    push_item(8'hFF, 64'h10A, 1'b0, 1'b0);
    push_item(8'hDD, 64'h10B, 1'b0, 1'b0);

    for (p = 0; p < PHASES; p++) begin
      for (r = 0; r < 4; r++) w[r] = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0:       mask = '1;
        1:       mask = $urandom;
        2:       mask = $urandom & $urandom;
        default: mask = $urandom | $urandom;
      endcase
      r = $urandom_range(0, 9);
      if (r < 6) len = 6'($urandom_range(1, 6));
      else if (r < 8) len = 6'($urandom_range(7, 16));
      else len = 6'($urandom_range(17, 40));
      case (p)
        0: begin
          len = 6'd32;
          mask = '1;
          for (r = 0; r < 4; r++) w[r] = '1;
        end
        1: begin
          len = 6'd0;
          mask = '0;
        end
        2: begin
          len = 6'd63;
          for (r = 0; r < 4; r++) w[r] = '0;
        end
        3: len = 6'd1;
        default: ;
      endcase
      load_config(w[0], w[1], w[2], w[3], mask, len);
      sender_gaps = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      receiver_gaps = (p == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
      scan_burst(PHASE_ITEMS / 2);
      // The sender holds off here until every match so far has been taken.
      wait_idle();
      scan_burst(PHASE_ITEMS - PHASE_ITEMS / 2);
    end

    wait_idle();
    $display("Scanned %0d bytes in %0d scans under %0d register settings.",
             accepted, scans_started, settings_used);
    $display("Checked %0d match addresses, %0d mismatches.", matches_checked, errors);
    if (errors == 0) begin
      $display("masked_byte_pattern_scanner_test passed");
    end else begin
      $display("masked_byte_pattern_scanner_test failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/mbps_pkg.sv
src/mbps_cell.sv
src/mbps_align.sv
src/masked_byte_pattern_scanner.sv
src/mbps_checker.sv
verif/masked_byte_pattern_scanner_test.sv
